FILE: rtl/core/ffs_pkg.sv
// shared types and constants for the feature support filter
package ffs_pkg;

    localparam int unsigned Entries = 32;

    localparam int unsigned AddrW = 3;

    // configuration register indexes
    localparam logic RegMinCount  = 1'b0;
    localparam logic RegMinLength = 1'b1;

    // input operations
    localparam logic OpAdd    = 1'b0;
    localparam logic OpFinish = 1'b1;

    // result status codes
    localparam logic [1:0] StDecision = 2'd0;
    localparam logic [1:0] StInvalid  = 2'd1;
    localparam logic [1:0] StEmpty    = 2'd2;

    // decision codes
    localparam logic [1:0] DecFew     = 2'd0;
    localparam logic [1:0] DecShort   = 2'd1;
    localparam logic [1:0] DecPassive = 2'd2;
    localparam logic [1:0] DecKept    = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [63:0] feature_id;
        logic [31:0] position_mm;
        logic        passive_flag;
        logic        upstream_ok;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_status;
        logic [63:0] out_feature_id;
        logic [15:0] out_sample_count;
        logic [31:0] support_length;
        logic [1:0]  decision_code;
        logic [6:0]  suppressed_total;
        logic [6:0]  passive_total;
        logic [6:0]  kept_total;
        logic        table_overflow;
        logic        last_result;
    } t_out;

    // one table entry as held in a cell
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [15:0] count;
        logic [31:0] min_pos;
        logic [31:0] max_pos;
        logic        passive;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ADD,
        CELL_SHIFT,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     insert;
    } t_cell_cmd;

endpackage

FILE: rtl/core/ffs_cell.sv
// one entry of the sorted id chain
module ffs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffs_pkg::t_cell_cmd i_cmd,
    input  logic [63:0]        i_key,
    input  logic [31:0]        i_pos,
    input  logic               i_passive,
    input  ffs_pkg::t_entry    i_left,
    input  ffs_pkg::t_entry    i_right,
    input  logic               i_left_ins,
    output ffs_pkg::t_entry    o_entry,
    output logic               o_ins,
    output logic               o_match
);

    ffs_pkg::t_entry r_entry;

    // sorted order: new id goes at the first empty or larger entry
    assign o_ins   = !r_entry.valid || (r_entry.key > i_key);
    assign o_match = r_entry.valid && (r_entry.key == i_key);
    assign o_entry = r_entry;

    // entry update, insert shift and drain shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                ffs_pkg::CELL_ADD: begin
                    if (o_match) begin
                        if ($signed(i_pos) < $signed(r_entry.min_pos)) r_entry.min_pos <= i_pos;
                        if ($signed(i_pos) > $signed(r_entry.max_pos)) r_entry.max_pos <= i_pos;
                        if (r_entry.count != 16'hFFFF) r_entry.count <= r_entry.count + 16'd1;
                    end else if (i_cmd.insert) begin
                        if (i_left_ins) begin
                            r_entry <= i_left;
                        end else if (o_ins) begin
                            r_entry <= '{valid: 1'b1, key: i_key, count: 16'd1,
                                         min_pos: i_pos, max_pos: i_pos,
                                         passive: i_passive};
                        end
                    end
                end
                ffs_pkg::CELL_SHIFT: r_entry <= i_right;
                ffs_pkg::CELL_CLEAR: r_entry.valid <= 1'b0;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/core/feature_support_filter.sv
// top level of the feature support filter
// A sample transfer is taken in S_IDLE; in S_ADD every cell of the id chain then compares its
// key at once and updates, inserts or shifts by one place. The chain is kept sorted by id, so a
// finish drains it from the head one decision per cycle when the output is free; a finish with
// invalid upstream or an empty table gives a single status result. Input is taken again once
// the finish run is done.
module feature_support_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ffs_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ffs_pkg::t_out                o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffs_pkg::AddrW-1:0]    paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int unsigned N = ffs_pkg::Entries;

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_EMIT} t_state;

    t_state           r_state;
    ffs_pkg::t_in     r_in;
    logic [15:0]      r_min_count;
    logic [31:0]      r_min_len;
    logic             r_overflow;
    logic [6:0]       r_sup, r_pas, r_kept;
    logic             r_out_valid;
    ffs_pkg::t_out    r_out;
    ffs_pkg::t_out    n_out;
    logic [6:0]       n_sup, n_pas, n_kept;

    ffs_pkg::t_cell_cmd s_cmd;
    ffs_pkg::t_entry    s_entry [N];
    logic [N-1:0]       s_ins, s_match;
    logic               s_slot_free;
    ffs_pkg::t_entry    s_head;
    logic [31:0]        s_len;
    logic [1:0]         s_code;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ffs_pkg::RegMinLength) ? r_min_len : {16'd0, r_min_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count <= 16'd3;
            r_min_len   <= 32'd1000;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ffs_pkg::RegMinLength) r_min_len <= pwdata;
            else                                   r_min_count <= pwdata[15:0];
        end
    end

    // chain of cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        ffs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (s_cmd),
            .i_key      (r_in.feature_id),
            .i_pos      (r_in.position_mm),
            .i_passive  (r_in.passive_flag),
            .i_left     ((g == 0) ? '0 : s_entry[(g == 0) ? 0 : g-1]),
            .i_right    ((g == N-1) ? '0 : s_entry[(g == N-1) ? g : g+1]),
            .i_left_ins ((g == 0) ? 1'b0 : s_ins[(g == 0) ? 0 : g-1]),
            .o_entry    (s_entry[g]),
            .o_ins      (s_ins[g]),
            .o_match    (s_match[g])
        );
    end

    // head decision
    assign s_head      = s_entry[0];
    assign s_len       = s_head.max_pos - s_head.min_pos;
    assign s_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (s_head.count < r_min_count)  s_code = ffs_pkg::DecFew;
        else if (s_len < r_min_len)      s_code = ffs_pkg::DecShort;
        else if (s_head.passive)         s_code = ffs_pkg::DecPassive;
        else                             s_code = ffs_pkg::DecKept;
    end

    // next result and running totals
    always_comb begin
        n_sup  = r_sup + 7'(s_code < ffs_pkg::DecPassive);
        n_pas  = r_pas + 7'(s_code == ffs_pkg::DecPassive);
        n_kept = r_kept + 7'(s_code == ffs_pkg::DecKept);
        n_out  = '0;
        n_out.table_overflow = r_overflow;
        if (!r_in.upstream_ok || !s_head.valid) begin
            n_out.result_status = r_in.upstream_ok ? ffs_pkg::StEmpty : ffs_pkg::StInvalid;
            n_out.last_result   = 1'b1;
        end else begin
            n_out.result_status    = ffs_pkg::StDecision;
            n_out.out_feature_id   = s_head.key;
            n_out.out_sample_count = s_head.count;
            n_out.support_length   = s_len;
            n_out.decision_code    = s_code;
            n_out.suppressed_total = n_sup;
            n_out.passive_total    = n_pas;
            n_out.kept_total       = n_kept;
            n_out.last_result      = !s_entry[1].valid;
        end
    end

    // chain command
    always_comb begin
        s_cmd.op     = ffs_pkg::CELL_HOLD;
        s_cmd.insert = (s_match == '0) && !s_entry[N-1].valid;
        case (r_state)
            S_ADD: s_cmd.op = ffs_pkg::CELL_ADD;
            S_EMIT: begin
                if (s_slot_free) begin
                    if (!r_in.upstream_ok || !s_head.valid) s_cmd.op = ffs_pkg::CELL_CLEAR;
                    else                                    s_cmd.op = ffs_pkg::CELL_SHIFT;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control, totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && s_slot_free) r_out_valid <= 1'b1;
            else if (i_out_ready)                 r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in  <= i_in_data;
                        r_sup <= 7'd0;
                        r_pas <= 7'd0;
                        r_kept <= 7'd0;
                        r_state <= (i_in_data.operation == ffs_pkg::OpFinish) ? S_EMIT : S_ADD;
                    end
                end
                S_ADD: begin
                    if ((s_match == '0) && s_entry[N-1].valid) r_overflow <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    if (s_slot_free) begin
                        r_out  <= n_out;
                        r_sup  <= n_sup;
                        r_pas  <= n_pas;
                        r_kept <= n_kept;
                        if (n_out.last_result) begin
                            r_overflow <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/ffs_checker.sv
// port-level checks for the feature support filter, bound to the top level
module ffs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input ffs_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ffs_pkg::t_out o_out_data
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // status results are single and carry no totals
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_status != ffs_pkg::StDecision |->
        o_out_data.last_result && o_out_data.kept_total == 7'd0 &&
        o_out_data.suppressed_total == 7'd0 && o_out_data.passive_total == 7'd0)
        else $error("status result malformed");

    // every decision counts in some total
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_status == ffs_pkg::StDecision |->
        (o_out_data.kept_total != 7'd0 || o_out_data.suppressed_total != 7'd0 ||
         o_out_data.passive_total != 7'd0))
        else $error("decision without totals");

    // input stops after a finish transfer
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.operation == ffs_pkg::OpFinish |=> !o_in_ready)
        else $error("input taken during finish run");

endmodule

bind feature_support_filter ffs_checker u_ffs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
